@@ src/sts_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sts_pkg
// Shared types, codes and the keyword table for the SQL token scanner.
// ----------------------------------------------------------------------------
package sts_pkg;

  localparam int TOKEN_MAX   = 64;
  localparam int KW_COUNT    = 56;
  localparam int KW_MAXLEN   = 8;
  localparam int RES_MAX     = 4;
  localparam int POS_W       = 12;
  localparam int LEN_W       = 7;

  // token kinds
  localparam logic [3:0] K_END     = 4'd0;
  localparam logic [3:0] K_OTHER   = 4'd1;
  localparam logic [3:0] K_IDENT   = 4'd2;
  localparam logic [3:0] K_INT     = 4'd3;
  localparam logic [3:0] K_FLOAT   = 4'd4;
  localparam logic [3:0] K_STRING  = 4'd5;
  localparam logic [3:0] K_PUNCT   = 4'd6;
  localparam logic [3:0] K_LE      = 4'd7;
  localparam logic [3:0] K_GE      = 4'd8;
  localparam logic [3:0] K_NE      = 4'd9;
  localparam logic [3:0] K_KEYWORD = 4'd10;

  // character codes
  localparam logic [7:0] CH_DOT   = 8'd46;
  localparam logic [7:0] CH_PLUS  = 8'd43;
  localparam logic [7:0] CH_MINUS = 8'd45;
  localparam logic [7:0] CH_LT    = 8'd60;
  localparam logic [7:0] CH_GT    = 8'd62;
  localparam logic [7:0] CH_BANG  = 8'd33;
  localparam logic [7:0] CH_EQ    = 8'd61;
  localparam logic [7:0] CH_QUOTE = 8'd39;
  localparam logic [7:0] CH_UNDER = 8'd95;

  typedef enum logic [3:0] {
    M_IDLE, M_IDENT, M_NUM, M_DOTP, M_SIGNP, M_SIGNDOT, M_CMPP, M_STR, M_OTHER
  } scan_mode_t;

  typedef struct packed {
    logic [3:0]       kind;
    logic [5:0]       kw;
    logic [7:0]       pc;
    logic [POS_W-1:0] start;
    logic [LEN_W-1:0] len;
    logic             trunc;
    logic             last;
  } tok_t;

  function automatic tok_t mk_tok(logic [3:0] kind, logic [5:0] kw, logic [7:0] pc,
                                  logic [POS_W-1:0] start, logic [LEN_W-1:0] len,
                                  logic trunc);
    tok_t t;
    t.kind = kind; t.kw = kw; t.pc = pc; t.start = start;
    t.len = len; t.trunc = trunc; t.last = 1'b0;
    return t;
  endfunction

  function automatic logic is_space(logic [7:0] c);
    return (c == 8'd32) || (c >= 8'd9 && c <= 8'd13);
  endfunction
  function automatic logic is_digit(logic [7:0] c);
    return c >= 8'd48 && c <= 8'd57;
  endfunction
  function automatic logic is_lower(logic [7:0] c);
    return c >= 8'd97 && c <= 8'd122;
  endfunction
  function automatic logic is_alpha(logic [7:0] c);
    return is_lower(c) || (c >= 8'd65 && c <= 8'd90);
  endfunction
  function automatic logic [7:0] to_upper(logic [7:0] c);
    return is_lower(c) ? c - 8'd32 : c;
  endfunction

  // single punctuation set: , ( ) [ ] : * ; / < > = "
  function automatic logic is_punct(logic [7:0] c);
    return c == 8'd44 || c == 8'd40 || c == 8'd41 || c == 8'd91 || c == 8'd93 ||
           c == 8'd58 || c == 8'd42 || c == 8'd59 || c == 8'd47 || c == 8'd60 ||
           c == 8'd62 || c == 8'd61 || c == 8'd34;
  endfunction

  // keyword text, first letter in the low byte
  function automatic logic [63:0] kw_text(int k);
    logic [63:0] s;
    case (k)
      0: s = "LLA";       1: s = "DNA";       2: s = "YNA";      3: s = "SA";
      4: s = "GVA";       5: s = "NEEWTEB";   6: s = "YB";       7: s = "RAHC";
      8: s = "KCEHC";     9: s = "ESOLC";     10: s = "TIMMOC";  11: s = "TNUOC";
      12: s = "ETAERC";   13: s = "LAMICED";  14: s = "ETELED";  15: s = "TCNITSID";
      16: s = "ELBUOD";   17: s = "PORD";     18: s = "STSIXE";  19: s = "TAOLF";
      20: s = "MORF";     21: s = "OG";       22: s = "PUORG";   23: s = "GNIVAH";
      24: s = "NI";       25: s = "TRESNI";   26: s = "TNI";     27: s = "OTNI";
      28: s = "SI";       29: s = "EKIL";     30: s = "XAM";     31: s = "NIM";
      32: s = "TON";      33: s = "LLUN";     34: s = "CIREMUN"; 35: s = "FO";
      36: s = "NO";       37: s = "RO";       38: s = "REDRO";   39: s = "YRAMIRP";
      40: s = "LAER";     41: s = "AMEHCS";   42: s = "TCELES";  43: s = "TES";
      44: s = "EMOS";     45: s = "MUS";      46: s = "ELBAT";   47: s = "OT";
      48: s = "NOINU";    49: s = "EUQINU";   50: s = "ETADPU";  51: s = "RESU";
      52: s = "SEULAV";   53: s = "WEIV";     54: s = "EREHW";   55: s = "HTIW";
      default: s = '0;
    endcase
    return s;
  endfunction

  function automatic logic [3:0] kw_len(logic [63:0] s);
    logic [3:0] n;
    n = '0;
    for (int i = 0; i < KW_MAXLEN; i++) begin
      if (s[8*i +: 8] != 8'd0) n = 4'(i + 1);
    end
    return n;
  endfunction

endpackage

@@ src/sql_token_scanner.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sql_token_scanner
// Streaming lexer: one command character per beat in, tokens out.
// ----------------------------------------------------------------------------
// Channel | dir | tdata                              | tuser      | tlast
// in_     | in  | char_code                          | -          | end_of_command
// out_    | out | keyword_index,punct_char,token_start,| token_kind | last_of_run
//         |     | token_length,truncated             |            |
// cfg_    | in  | sign_mode (cfg_data)               | -          | -
//
// One character is scanned per cycle into a four-entry token buffer, unless it is still draining.
// A character that yields more than one token holds the input until the buffer
// drain port (one token per cycle while out_tready is high) has sent them.
// A new character is taken while the last buffered token is leaving.
// Reset (rst_n low, synchronous) returns the scanner to idle, sign_mode 0.
// cfg_ready is always high.
module sql_token_scanner (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] char_code
  input  logic        in_tlast,   // end_of_command
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // [5:0] keyword_index, [13:6] punct_char,
                                  // [25:14] token_start, [32:26] token_length,
                                  // [33] truncated, [39:34] zero
  output logic [3:0]  out_tuser,  // [3:0] token_kind
  output logic        out_tlast,  // last_of_run
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_data
);
  import sts_pkg::*;

  // scanner state
  scan_mode_t       mode_r, mode_nxt;
  logic [POS_W-1:0] spos_r, spos_nxt, cpos_r, cpos_nxt;
  logic [LEN_W-1:0] tlen_r, tlen_nxt;
  logic [63:0]      up_r, up_nxt;
  logic             dot_r, dot_nxt;
  logic [7:0]       held_r, held_nxt;
  logic             sign_mode_r;

  // token buffer
  tok_t             buf_r [RES_MAX];
  tok_t             res   [RES_MAX];
  logic [2:0]       rem_r, cnt;
  logic [1:0]       idx_r;

  logic       in_fire, out_fire;
  logic [7:0] c;
  logic       used, new_str;
  logic [5:0] kw_hit;
  logic       kw_found;

  assign c         = in_tdata;
  assign cfg_ready = 1'b1;
  assign in_fire   = in_tvalid & in_tready;
  assign out_fire  = out_tvalid & out_tready;
  assign in_tready = (rem_r == 3'd0) || (rem_r == 3'd1 && out_tready);

  // keyword lookup on the held word
  always_comb begin
    kw_hit   = '0;
    kw_found = 1'b0;
    for (int k = 0; k < KW_COUNT; k++) begin
      if (!kw_found && up_r == kw_text(k) && tlen_r == LEN_W'(kw_len(kw_text(k)))) begin
        kw_found = 1'b1;
        kw_hit   = 6'(k);
      end
    end
  end

  // scan one character
  always_comb begin
    logic [POS_W-1:0] p;
    logic             do_close, close_trunc;
    tok_t             c0, c1;
    logic [1:0]       cn;
    p           = cpos_r;
    mode_nxt    = mode_r;
    spos_nxt    = spos_r;
    tlen_nxt    = tlen_r;
    up_nxt      = up_r;
    dot_nxt     = dot_r;
    held_nxt    = held_r;
    cpos_nxt    = cpos_r;
    used        = 1'b0;
    new_str     = 1'b0;
    do_close    = 1'b0;
    close_trunc = 1'b0;
    cnt         = '0;
    for (int i = 0; i < RES_MAX; i++) res[i] = '0;

    // tokens the open state would close with (from current registers)
    c0 = '0; c1 = '0; cn = 2'd0;
    case (mode_r)
      M_IDENT: begin
        cn = 2'd1;
        c0 = kw_found ? mk_tok(K_KEYWORD, kw_hit, 8'd0, spos_r, tlen_r, 1'b0)
                      : mk_tok(K_IDENT, 6'd0, 8'd0, spos_r, tlen_r, 1'b0);
      end
      M_NUM: begin
        cn = 2'd1;
        c0 = mk_tok(dot_r ? K_FLOAT : K_INT, 6'd0, 8'd0, spos_r, tlen_r, 1'b0);
      end
      M_STR:   begin cn = 2'd1; c0 = mk_tok(K_STRING, 6'd0, 8'd0, spos_r, tlen_r, 1'b0); end
      M_OTHER: begin cn = 2'd1; c0 = mk_tok(K_OTHER, 6'd0, 8'd0, spos_r, tlen_r, 1'b0); end
      M_DOTP:  begin cn = 2'd1; c0 = mk_tok(K_PUNCT, 6'd0, CH_DOT, spos_r, 7'd1, 1'b0); end
      M_SIGNP, M_CMPP: begin
        cn = 2'd1; c0 = mk_tok(K_PUNCT, 6'd0, held_r, spos_r, 7'd1, 1'b0);
      end
      M_SIGNDOT: begin
        cn = 2'd2;
        c0 = mk_tok(K_PUNCT, 6'd0, held_r, spos_r, 7'd1, 1'b0);
        c1 = mk_tok(K_PUNCT, 6'd0, CH_DOT, spos_r + 1'b1, 7'd1, 1'b0);
      end
      default: cn = 2'd0;
    endcase

    // continue the open token
    case (mode_r)
      M_IDENT: begin
        if (is_alpha(c) || is_digit(c) || c == CH_UNDER) begin
          if (tlen_r < LEN_W'(TOKEN_MAX)) begin
            used = 1'b1; tlen_nxt = tlen_r + 1'b1;
            if (tlen_r < LEN_W'(KW_MAXLEN)) up_nxt[8*tlen_r[2:0] +: 8] = to_upper(c);
          end else begin
            do_close = 1'b1; close_trunc = 1'b1;
          end
        end else do_close = 1'b1;
      end
      M_NUM: begin
        if (is_digit(c) || (c == CH_DOT && !dot_r)) begin
          if (tlen_r < LEN_W'(TOKEN_MAX)) begin
            used = 1'b1; tlen_nxt = tlen_r + 1'b1;
            if (c == CH_DOT) dot_nxt = 1'b1;
          end else begin
            do_close = 1'b1; close_trunc = 1'b1;
          end
        end else do_close = 1'b1;
      end
      M_DOTP: begin
        if (is_digit(c)) begin
          mode_nxt = M_NUM; dot_nxt = 1'b1; tlen_nxt = 7'd2; used = 1'b1;
        end else do_close = 1'b1;
      end
      M_SIGNP: begin
        if (is_digit(c)) begin
          mode_nxt = M_NUM; dot_nxt = 1'b0; tlen_nxt = 7'd2; used = 1'b1;
        end else if (c == CH_DOT) begin
          mode_nxt = M_SIGNDOT; tlen_nxt = 7'd2; used = 1'b1;
        end else do_close = 1'b1;
      end
      M_SIGNDOT: begin
        if (is_digit(c)) begin
          mode_nxt = M_NUM; dot_nxt = 1'b1; tlen_nxt = 7'd3; used = 1'b1;
        end else do_close = 1'b1;
      end
      M_CMPP: begin
        if (c == CH_EQ) begin
          res[0] = mk_tok(held_r == CH_LT ? K_LE : (held_r == CH_GT ? K_GE : K_NE),
                          6'd0, 8'd0, spos_r, 7'd2, 1'b0);
          cnt = 3'd1; mode_nxt = M_IDLE; used = 1'b1;
        end else do_close = 1'b1;
      end
      M_STR: begin
        if (c == CH_QUOTE) begin
          do_close = 1'b1; used = 1'b1;
        end else if (tlen_r < LEN_W'(TOKEN_MAX)) begin
          used = 1'b1; tlen_nxt = tlen_r + 1'b1;
        end else begin
          do_close = 1'b1; close_trunc = 1'b1;
        end
      end
      M_OTHER: begin
        if (is_space(c)) do_close = 1'b1;
        else if (tlen_r < LEN_W'(TOKEN_MAX)) begin
          used = 1'b1; tlen_nxt = tlen_r + 1'b1;
        end else begin
          do_close = 1'b1; close_trunc = 1'b1;
        end
      end
      default: mode_nxt = M_IDLE;
    endcase

    if (do_close) begin
      c0.trunc = close_trunc;
      if (cn != 2'd0) begin res[0] = c0; cnt = 3'd1; end
      if (cn == 2'd2) begin res[1] = c1; cnt = 3'd2; end
      mode_nxt = M_IDLE;
    end

    // fresh scan from idle
    if (!used && !is_space(c)) begin
      if (is_alpha(c) || is_digit(c) || c == CH_DOT || c == CH_LT || c == CH_GT ||
          c == CH_BANG || ((c == CH_PLUS || c == CH_MINUS) && !sign_mode_r) ||
          (c == CH_QUOTE) || !is_punct(c) && !(c == CH_PLUS || c == CH_MINUS)) begin
        spos_nxt = p; tlen_nxt = 7'd1; up_nxt = '0; dot_nxt = 1'b0;
      end
      if (is_alpha(c)) begin
        mode_nxt = M_IDENT; up_nxt[7:0] = to_upper(c);
      end else if (is_digit(c)) mode_nxt = M_NUM;
      else if (c == CH_DOT) mode_nxt = M_DOTP;
      else if (c == CH_PLUS || c == CH_MINUS) begin
        if (!sign_mode_r) begin
          mode_nxt = M_SIGNP; held_nxt = c;
        end else begin
          res[cnt[1:0]] = mk_tok(K_PUNCT, 6'd0, c, p, 7'd1, 1'b0); cnt = cnt + 1'b1;
        end
      end else if (c == CH_LT || c == CH_GT || c == CH_BANG) begin
        mode_nxt = M_CMPP; held_nxt = c;
      end else if (c == CH_QUOTE) begin
        mode_nxt = M_STR; spos_nxt = p + 1'b1; tlen_nxt = 7'd0; new_str = 1'b1;
      end else if (is_punct(c)) begin
        res[cnt[1:0]] = mk_tok(K_PUNCT, 6'd0, c, p, 7'd1, 1'b0); cnt = cnt + 1'b1;
      end else mode_nxt = M_OTHER;
    end

    // end of command: flush, end token, back to reset values
    if (in_tlast) begin
      if (!new_str && mode_nxt != M_IDLE) begin
        c0 = '0; c1 = '0;
        case (mode_nxt)
          M_IDENT, M_NUM, M_STR, M_OTHER: begin
            c0 = mk_tok(K_OTHER, 6'd0, 8'd0, spos_nxt, tlen_nxt, 1'b0);
          end
          default: c0 = '0;
        endcase
        // recompute kind for the flushed word
        case (mode_nxt)
          M_IDENT: begin
            c0.kind = K_IDENT;
            for (int k = 0; k < KW_COUNT; k++) begin
              if (c0.kind == K_IDENT && up_nxt == kw_text(k) &&
                  tlen_nxt == LEN_W'(kw_len(kw_text(k)))) begin
                c0.kind = K_KEYWORD; c0.kw = 6'(k);
              end
            end
            res[cnt[1:0]] = c0; cnt = cnt + 1'b1;
          end
          M_NUM: begin
            c0.kind = dot_nxt ? K_FLOAT : K_INT; res[cnt[1:0]] = c0; cnt = cnt + 1'b1;
          end
          M_STR: begin
            c0.kind = K_STRING; res[cnt[1:0]] = c0; cnt = cnt + 1'b1;
          end
          M_OTHER: begin
            res[cnt[1:0]] = c0; cnt = cnt + 1'b1;
          end
          M_DOTP: begin
            res[cnt[1:0]] = mk_tok(K_PUNCT, 6'd0, CH_DOT, spos_nxt, 7'd1, 1'b0);
            cnt = cnt + 1'b1;
          end
          M_SIGNP, M_CMPP: begin
            res[cnt[1:0]] = mk_tok(K_PUNCT, 6'd0, held_nxt, spos_nxt, 7'd1, 1'b0);
            cnt = cnt + 1'b1;
          end
          M_SIGNDOT: begin
            res[cnt[1:0]] = mk_tok(K_PUNCT, 6'd0, held_nxt, spos_nxt, 7'd1, 1'b0);
            cnt = cnt + 1'b1;
            res[cnt[1:0]] = mk_tok(K_PUNCT, 6'd0, CH_DOT, spos_nxt + 1'b1, 7'd1, 1'b0);
            cnt = cnt + 1'b1;
          end
          default: cnt = cnt;
        endcase
      end
      res[cnt[1:0]] = mk_tok(K_END, 6'd0, 8'd0, p + 1'b1, 7'd0, 1'b0);
      cnt      = cnt + 1'b1;
      mode_nxt = M_IDLE; spos_nxt = '0; tlen_nxt = '0; up_nxt = '0;
      dot_nxt  = 1'b0;   held_nxt = '0; cpos_nxt = '0;
    end else begin
      cpos_nxt = p + 1'b1;
    end

    if (cnt != 3'd0) res[cnt[1:0] - 2'd1].last = 1'b1;
  end

  // scanner state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= M_IDLE; spos_r <= '0; tlen_r <= '0; up_r <= '0;
      dot_r  <= 1'b0;   held_r <= '0; cpos_r <= '0; sign_mode_r <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) sign_mode_r <= cfg_data;
      if (in_fire) begin
        mode_r <= mode_nxt; spos_r <= spos_nxt; tlen_r <= tlen_nxt; up_r <= up_nxt;
        dot_r  <= dot_nxt;  held_r <= held_nxt; cpos_r <= cpos_nxt;
      end
    end
  end

  // token buffer control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rem_r <= '0; idx_r <= '0;
    end else if (in_fire) begin
      rem_r <= cnt; idx_r <= '0;
    end else if (out_fire) begin
      rem_r <= rem_r - 1'b1; idx_r <= idx_r + 1'b1;
    end
  end

  // token buffer payload
  always_ff @(posedge clk) begin
    if (in_fire) begin
      for (int i = 0; i < RES_MAX; i++) buf_r[i] <= res[i];
    end
  end

  // output beat
  tok_t cur;
  assign cur        = buf_r[idx_r];
  assign out_tvalid = rem_r != 3'd0;
  assign out_tuser  = cur.kind;
  assign out_tlast  = cur.last;
  assign out_tdata  = {6'd0, cur.trunc, cur.len, cur.start, cur.pc, cur.kw};

`ifndef SYNTHESIS
  a_rem_range: assert property (@(posedge clk) disable iff (!rst_n)
    rem_r <= 3'd4) else $error("token buffer count out of range");
  a_end_resets: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && in_tlast |=> mode_r == M_IDLE && cpos_r == '0)
    else $error("scanner not idle after command end");
  a_last_on_final: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && rem_r == 3'd1 |-> out_tlast)
    else $error("final buffered token lacks last_of_run");
  a_end_token: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && in_tlast |=> rem_r != 3'd0)
    else $error("command end produced no tokens");
`endif

endmodule
